FILE: sv/swam_pkg.sv
// Shared constants and types for the sliding-window anagram matcher.
package swam_pkg;

   localparam int MAX_PATTERN = 64;
   localparam int ALPHABET    = 26;

   localparam int FUNC_W   = 2;
   localparam int LETTER_W = 5;
   localparam int CNT_W    = $clog2(MAX_PATTERN + 1);
   localparam int RING_AW  = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
   localparam int DIFF_W   = CNT_W + 1;
   localparam int BACK_W   = CNT_W + 1;

   localparam logic [FUNC_W-1:0] FUNC_CLEAR   = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_PATTERN = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_TEXT    = 2'd2;

   typedef struct packed {
      logic                clear;
      logic                pat_inc;
      logic                win_inc;
      logic                win_dec;
      logic [LETTER_W-1:0] inc_letter;
      logic [LETTER_W-1:0] dec_letter;
   } bin_ctrl_type;

endpackage

FILE: sv/swam_ram.sv
// Generic single-write, single-read RAM with registered read data.
module swam_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                                    clock,
   input  logic                                    wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                        wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                        rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: sv/swam_bins.sv
// Per-letter lanes holding window minus pattern counts, with all-equal detect.
module swam_bins (
   input  logic                  clock,
   input  logic                  reset,
   input  swam_pkg::bin_ctrl_type ctrl,
   output logic                  all_equal_next
);

   logic [swam_pkg::DIFF_W-1:0] diff_ff [swam_pkg::ALPHABET];
   logic [swam_pkg::DIFF_W-1:0] diff_in [swam_pkg::ALPHABET];
   logic [swam_pkg::ALPHABET-1:0] zero_in;

   for (genvar i = 0; i < swam_pkg::ALPHABET; i++) begin : g_lane
      logic hit_inc;
      logic hit_dec;
      logic up;
      logic down;

      assign hit_inc = (ctrl.inc_letter == swam_pkg::LETTER_W'(i));
      assign hit_dec = (ctrl.dec_letter == swam_pkg::LETTER_W'(i));
      // pattern letter lowers the difference, window letters move it both ways
      assign up   = ctrl.win_inc && hit_inc;
      assign down = (ctrl.pat_inc && hit_inc) ^ (ctrl.win_dec && hit_dec);

      always_comb begin
         if (ctrl.clear) begin
            diff_in[i] = '0;
         end else if (up && !down) begin
            diff_in[i] = diff_ff[i] + swam_pkg::DIFF_W'(1);
         end else if (down && !up) begin
            diff_in[i] = diff_ff[i] - swam_pkg::DIFF_W'(1);
         end else begin
            diff_in[i] = diff_ff[i];
         end
      end

      assign zero_in[i] = (diff_in[i] == '0);

      always_ff @(posedge clock) begin
         if (reset) begin
            diff_ff[i] <= '0;
         end else begin
            diff_ff[i] <= diff_in[i];
         end
      end
   end

   assign all_equal_next = &zero_in;

endmodule

FILE: sv/sliding_window_anagram_match.sv
// Top level of the sliding-window anagram matcher.
//
//  channel | ports                                   | role
//  --------+-----------------------------------------+------------------------------
//  req     | req_valid req_stall req_func req_letter | clear / pattern / text items
//  rsp     | rsp_valid rsp_stall rsp_window_full     | one per in-range text item
//          | rsp_window_match rsp_found              |
//
//  One transaction per cycle: one short combinational pass between the input
//  register and the result register; a result is offered once its request is
//  processed. Synchronous active-high reset clears control state and bin
//  lanes; the history ring is not cleared, as only entries written since the
//  last clear are read. A stalled result holds the pipeline, and the input
//  register takes a new transaction whenever the result register moves.
module sliding_window_anagram_match (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [swam_pkg::FUNC_W-1:0]   req_func,
   input  logic [swam_pkg::LETTER_W-1:0] req_letter,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic                          rsp_window_full,
   output logic                          rsp_window_match,
   output logic                          rsp_found
);

   // input register
   logic                          in_valid_ff;
   logic [swam_pkg::FUNC_W-1:0]   in_func_ff;
   logic [swam_pkg::LETTER_W-1:0] in_letter_ff;

   // search state
   logic [swam_pkg::RING_AW-1:0] ptr_ff,  ptr_in;
   logic [swam_pkg::CNT_W-1:0]   plen_ff, plen_in;
   logic [swam_pkg::CNT_W-1:0]   fill_ff, fill_in;
   logic                         text_ff, text_in;
   logic                         found_ff, found_in;

   // ring read-during-write bypass
   logic                          byp_ff;
   logic [swam_pkg::LETTER_W-1:0] byp_data_ff;

   // result register
   logic rsp_valid_ff;
   logic full_ff, match_ff, found_out_ff;

   logic advance, proc, letter_ok;
   logic clr_ev, pat_ev, txt_ev, win_ev, remove;
   logic full_now, match_now, all_equal_next;
   logic [swam_pkg::BACK_W-1:0]   back_sum;
   logic [swam_pkg::RING_AW-1:0]  rd_addr;
   logic [swam_pkg::LETTER_W-1:0] ring_rd, gone;
   swam_pkg::bin_ctrl_type        bin_ctrl;

   // pipeline moves whenever the result register is empty or being taken
   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign req_stall = in_valid_ff && !advance;
   assign proc      = in_valid_ff && advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_func_ff   <= req_func;
         in_letter_ff <= req_letter;
      end
   end

   // decode of the transaction in the input register
   assign letter_ok = (in_letter_ff < swam_pkg::LETTER_W'(swam_pkg::ALPHABET));

   always_comb begin
      clr_ev = 1'b0;
      pat_ev = 1'b0;
      txt_ev = 1'b0;
      unique case (in_func_ff)
         swam_pkg::FUNC_CLEAR:   clr_ev = proc;
         swam_pkg::FUNC_PATTERN: pat_ev = proc && letter_ok && !text_ff &&
                                          (plen_ff < swam_pkg::CNT_W'(swam_pkg::MAX_PATTERN));
         swam_pkg::FUNC_TEXT:    txt_ev = proc && letter_ok;
         default: ;
      endcase
   end

   // empty pattern: text is reported but the window never moves
   assign win_ev = txt_ev && (plen_ff != '0);
   assign remove = win_ev && (fill_ff >= plen_ff);

   // oldest letter of a full window; bypass covers a ring write that the registered read has not yet seen
   assign gone = byp_ff ? byp_data_ff : ring_rd;

   always_comb begin
      bin_ctrl.clear      = clr_ev;
      bin_ctrl.pat_inc    = pat_ev;
      bin_ctrl.win_inc    = win_ev;
      bin_ctrl.win_dec    = remove;
      bin_ctrl.inc_letter = in_letter_ff;
      bin_ctrl.dec_letter = gone;
   end

   swam_bins u_bins (
      .clock          (clock),
      .reset          (reset),
      .ctrl           (bin_ctrl),
      .all_equal_next (all_equal_next)
   );

   always_comb begin
      ptr_in   = ptr_ff;
      plen_in  = plen_ff;
      fill_in  = fill_ff;
      text_in  = text_ff;
      found_in = found_ff;
      if (clr_ev) begin
         ptr_in   = '0;
         plen_in  = '0;
         fill_in  = '0;
         text_in  = 1'b0;
         found_in = 1'b0;
      end else begin
         if (pat_ev) begin
            plen_in = plen_ff + swam_pkg::CNT_W'(1);
         end
         if (txt_ev) begin
            text_in = 1'b1;
         end
         if (win_ev) begin
            if (!remove) begin
               fill_in = fill_ff + swam_pkg::CNT_W'(1);
            end
            if (ptr_ff == swam_pkg::RING_AW'(swam_pkg::MAX_PATTERN - 1)) begin
               ptr_in = '0;
            end else begin
               ptr_in = ptr_ff + swam_pkg::RING_AW'(1);
            end
         end
         if (txt_ev && match_now) begin
            found_in = 1'b1;
         end
      end
   end

   assign full_now  = (fill_in == plen_ff);
   assign match_now = full_now && all_equal_next;

   // prefetch the slot that leaves the window on the next text letter
   assign back_sum = swam_pkg::BACK_W'(ptr_in) + swam_pkg::BACK_W'(swam_pkg::MAX_PATTERN)
                     - swam_pkg::BACK_W'(plen_in);
   always_comb begin
      if (back_sum >= swam_pkg::BACK_W'(swam_pkg::MAX_PATTERN)) begin
         rd_addr = swam_pkg::RING_AW'(back_sum - swam_pkg::BACK_W'(swam_pkg::MAX_PATTERN));
      end else begin
         rd_addr = swam_pkg::RING_AW'(back_sum);
      end
   end

   swam_ram #(
      .WIDTH (swam_pkg::LETTER_W),
      .DEPTH (swam_pkg::MAX_PATTERN)
   ) u_ring (
      .clock   (clock),
      .wr_en   (win_ev),
      .wr_addr (ptr_ff),
      .wr_data (in_letter_ff),
      .rd_addr (rd_addr),
      .rd_data (ring_rd)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         ptr_ff   <= '0;
         plen_ff  <= '0;
         fill_ff  <= '0;
         text_ff  <= 1'b0;
         found_ff <= 1'b0;
         byp_ff   <= 1'b0;
      end else begin
         ptr_ff   <= ptr_in;
         plen_ff  <= plen_in;
         fill_ff  <= fill_in;
         text_ff  <= text_in;
         found_ff <= found_in;
         byp_ff   <= win_ev && (rd_addr == ptr_ff);
      end
   end

   always_ff @(posedge clock) begin
      byp_data_ff <= in_letter_ff;
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= txt_ev;
      end
   end

   always_ff @(posedge clock) begin
      if (txt_ev) begin
         full_ff      <= full_now;
         match_ff     <= match_now;
         found_out_ff <= found_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_window_full  = full_ff;
   assign rsp_window_match = match_ff;
   assign rsp_found        = found_out_ff;

endmodule
